>>> hw/rtl/audio_cv_input_conditioner_macros.svh
// assertion helpers for the conditioner rtl
`ifndef AUDIO_CV_INPUT_CONDITIONER_MACROS_SVH
`define AUDIO_CV_INPUT_CONDITIONER_MACROS_SVH

// same-cycle implication, checked outside reset
`define ACIC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ACIC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/acic_pkg.sv
package acic_pkg;

   // request / response payload widths
   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned REQ_DATA_W = 56;
   localparam int unsigned RSP_DATA_W = 80;
   localparam int unsigned ENV_OUT_W  = 13;

   // conditioner state widths
   localparam int unsigned ENV_W   = 20;
   localparam int unsigned CNT_W   = 16;
   localparam int unsigned SHIFT_W = 5;
   localparam int unsigned ATTACK_SHIFT = 8;
   localparam int unsigned ENV_OUT_SHIFT = 7;

   // csr port
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;

   localparam csr_addr_type CSR_PULSE_HOLD_TICKS = 3'd0;
   localparam csr_addr_type CSR_RELEASE_SHIFT    = 3'd1;
   localparam csr_addr_type CSR_ZCR_WINDOW_LEN   = 3'd2;
   localparam csr_addr_type CSR_ZCR_THRESHOLD    = 3'd3;
   localparam csr_addr_type CSR_ZCR_GAIN         = 3'd4;

   // csr reset values
   localparam logic [CNT_W-1:0]    PULSE_HOLD_RESET = 16'd480;
   localparam logic [SHIFT_W-1:0]  RELEASE_SHIFT_RESET = 5'd12;
   localparam logic [CNT_W-1:0]    ZCR_WINDOW_RESET = 16'd960;
   localparam logic [SAMPLE_W-1:0] ZCR_THRESHOLD_RESET = 12'd30;
   localparam logic [SAMPLE_W-1:0] ZCR_GAIN_RESET = 12'd50;

   // full-scale level for pulse outputs and rate saturation
   localparam logic [SAMPLE_W-1:0] LEVEL_FULL = 12'd4095;

   // largest envelope value: full-scale magnitude after attack shift
   localparam logic [ENV_W-1:0] ENV_MAX = 20'h80000;

endpackage

>>> hw/rtl/audio_cv_input_conditioner.sv
// channel   | dir | width | fields (lowest bit up)
// req_      | in  | 56    | audio_a, audio_b, cv_a, cv_b, pulse_a_rise, pulse_b_rise
// rsp_      | out | 80    | envelope, crossing_rate, cv_a_mean, cv_b_mean,
//           |     |       | pulse_a_level, pulse_b_level
// csr_      | in  | 16    | write only, index selects the register
//
// one request per cycle sustained while responses are taken; a response passes
// through the input register, then the result register, after its request is taken
// the longest per-request path is the cv block-average reciprocal multiply
// synchronous reset returns all conditioner state and csrs to defaults
// a stalled response holds the result register and backs up into the
// input register; req_tready drops only when both are full

`include "audio_cv_input_conditioner_macros.svh"

module audio_cv_input_conditioner #(
   parameter int unsigned AVG_WINDOW = 480
) (
   input  logic                                clock,
   input  logic                                reset,
   // request
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // audio_a, audio_b, cv_a, cv_b, pulse_a_rise, pulse_b_rise, zero fill
   input  logic [acic_pkg::REQ_DATA_W-1:0]     req_tdata,
   // response
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // envelope, crossing_rate, cv_a_mean, cv_b_mean, pulse_a_level,
   // pulse_b_level, zero fill
   output logic [acic_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // csr write
   input  logic                                csr_we,
   input  logic [acic_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [acic_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // block average sizing: sum, magnitude, position and reciprocal
   localparam int unsigned POS_W   = $clog2(AVG_WINDOW + 1);
   localparam int unsigned SUM_W   = acic_pkg::SAMPLE_W + POS_W;
   localparam int unsigned MAG_W   = SUM_W - 1;
   localparam int unsigned DIV_K   = MAG_W + POS_W;
   localparam int unsigned RECIP_W = DIV_K + 1;
   localparam int unsigned PROD_W  = MAG_W + RECIP_W;
   localparam int unsigned QUOT_W  = acic_pkg::SAMPLE_W + 1;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << DIV_K) + 64'(AVG_WINDOW) - 64'd1) / 64'(AVG_WINDOW));
   localparam logic [POS_W-1:0] WINDOW_LEN = POS_W'(AVG_WINDOW);

   localparam int unsigned SW = acic_pkg::SAMPLE_W;
   localparam int unsigned CW = acic_pkg::CNT_W;
   localparam int unsigned EW = acic_pkg::ENV_W;

   // csr registers
   logic [CW-1:0]                    hold_ticks_ff;
   logic [acic_pkg::SHIFT_W-1:0]     rel_shift_ff;
   logic [CW-1:0]                    zcr_len_ff;
   logic [SW-1:0]                    zcr_thr_ff;
   logic [SW-1:0]                    zcr_gain_ff;

   // pipeline registers
   logic                             req_valid_ff;
   logic [acic_pkg::REQ_DATA_W-1:0]  req_data_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic [acic_pkg::RSP_DATA_W-1:0]  rsp_data_ff, rsp_data_in;
   logic                             rsp_free;
   logic                             advance;

   // conditioner state
   logic [CW-1:0]                    hold_cnt_ff[2], hold_cnt_in[2];
   logic                             pulse_act_ff[2], pulse_act_in[2];
   logic [EW-1:0]                    env_ff, env_in;
   logic                             prev_nonneg_ff, prev_nonneg_in;
   logic [CW-1:0]                    cross_cnt_ff, cross_cnt_in;
   logic [CW-1:0]                    win_pos_ff, win_pos_in;
   logic [SW-1:0]                    rate_ff, rate_in;
   logic signed [SUM_W-1:0]          cv_sum_ff[2], cv_sum_in[2];
   logic [POS_W-1:0]                 avg_pos_ff, avg_pos_in;
   logic signed [SW-1:0]             cv_mean_ff[2], cv_mean_in[2];

   // unpacked request fields
   logic signed [SW-1:0]             audio_a, audio_b;
   logic signed [SW-1:0]             cv_smp[2];
   logic                             pulse_rise[2];

   // datapath intermediates
   logic [SW-1:0]                    mag_a, mag_b;
   logic [EW-1:0]                    attack, release_step;
   logic                             nonneg_b, crossing;
   logic [CW-1:0]                    cnt_inc, win_next;
   logic                             zcr_done;
   logic [CW+SW-1:0]                 scaled;
   logic [POS_W-1:0]                 avg_next;
   logic                             avg_done;
   logic signed [SUM_W-1:0]          sum_next[2];
   logic [MAG_W-1:0]                 sum_mag[2];
   logic [PROD_W-1:0]                div_prod[2];
   logic [QUOT_W-1:0]                quot[2];

   // check terms
   logic                             pulse_idle_ok;
   logic                             win_close;
   logic                             win_clear;

   // handshake: the result register frees when empty or taken
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign advance    = req_valid_ff && rsp_free;
   assign req_tready = !req_valid_ff || rsp_free;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // csr writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ticks_ff <= acic_pkg::PULSE_HOLD_RESET;
         rel_shift_ff  <= acic_pkg::RELEASE_SHIFT_RESET;
         zcr_len_ff    <= acic_pkg::ZCR_WINDOW_RESET;
         zcr_thr_ff    <= acic_pkg::ZCR_THRESHOLD_RESET;
         zcr_gain_ff   <= acic_pkg::ZCR_GAIN_RESET;
      end else if (csr_we) begin
         unique case (csr_addr)
            acic_pkg::CSR_PULSE_HOLD_TICKS: hold_ticks_ff <= csr_wdata;
            acic_pkg::CSR_RELEASE_SHIFT:    rel_shift_ff <= csr_wdata[acic_pkg::SHIFT_W-1:0];
            acic_pkg::CSR_ZCR_WINDOW_LEN:   zcr_len_ff <= csr_wdata;
            acic_pkg::CSR_ZCR_THRESHOLD:    zcr_thr_ff <= csr_wdata[SW-1:0];
            acic_pkg::CSR_ZCR_GAIN:         zcr_gain_ff <= csr_wdata[SW-1:0];
            default: ;
         endcase
      end
   end

   // request field unpack
   assign audio_a       = req_data_ff[SW-1:0];
   assign audio_b       = req_data_ff[2*SW-1:SW];
   assign cv_smp[0]     = req_data_ff[3*SW-1:2*SW];
   assign cv_smp[1]     = req_data_ff[4*SW-1:3*SW];
   assign pulse_rise[0] = req_data_ff[4*SW];
   assign pulse_rise[1] = req_data_ff[4*SW+1];

   // pulse hold-stretch
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         hold_cnt_in[i]  = hold_cnt_ff[i];
         pulse_act_in[i] = pulse_act_ff[i];
         if (pulse_rise[i]) begin
            pulse_act_in[i] = 1'b1;
            hold_cnt_in[i]  = hold_ticks_ff;
         end else if (hold_cnt_ff[i] != '0) begin
            hold_cnt_in[i] = hold_cnt_ff[i] - CW'(1);
         end else begin
            pulse_act_in[i] = 1'b0;
         end
      end
   end

   // peak envelope: instant attack, release by shifted self
   assign mag_a        = audio_a[SW-1] ? SW'(-audio_a) : SW'(audio_a);
   assign attack       = {mag_a, {acic_pkg::ATTACK_SHIFT{1'b0}}};
   assign release_step = env_ff >> rel_shift_ff;
   assign env_in       = (attack > env_ff) ? attack : env_ff - release_step;

   // zero-crossing count over a window
   assign mag_b     = audio_b[SW-1] ? SW'(-audio_b) : SW'(audio_b);
   assign nonneg_b  = !audio_b[SW-1];
   assign crossing  = (mag_b > zcr_thr_ff) && (nonneg_b != prev_nonneg_ff);
   assign cnt_inc   = (crossing && cross_cnt_ff != '1) ? cross_cnt_ff + CW'(1) : cross_cnt_ff;
   assign win_next  = win_pos_ff + CW'(1);
   assign zcr_done  = (win_next >= zcr_len_ff) || (win_next == '0);
   assign scaled    = (CW+SW)'(cnt_inc) * (CW+SW)'(zcr_gain_ff);
   assign prev_nonneg_in = nonneg_b;

   always_comb begin
      rate_in      = rate_ff;
      cross_cnt_in = cnt_inc;
      win_pos_in   = win_next;
      if (zcr_done) begin
         rate_in      = (scaled > (CW+SW)'(acic_pkg::LEVEL_FULL)) ?
                        acic_pkg::LEVEL_FULL : scaled[SW-1:0];
         cross_cnt_in = '0;
         win_pos_in   = '0;
      end
   end

   // cv block average, divide by reciprocal multiply toward zero
   assign avg_next = avg_pos_ff + POS_W'(1);
   assign avg_done = (avg_next >= WINDOW_LEN);
   assign avg_pos_in = avg_done ? '0 : avg_next;

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         sum_next[i] = cv_sum_ff[i] + SUM_W'(cv_smp[i]);
         sum_mag[i]  = sum_next[i][SUM_W-1] ? MAG_W'(-sum_next[i]) : MAG_W'(sum_next[i]);
         div_prod[i] = PROD_W'(sum_mag[i]) * PROD_W'(RECIP);
         quot[i]     = QUOT_W'(div_prod[i] >> DIV_K);
         cv_sum_in[i]  = avg_done ? '0 : sum_next[i];
         cv_mean_in[i] = cv_mean_ff[i];
         if (avg_done) begin
            cv_mean_in[i] = sum_next[i][SUM_W-1] ? SW'(-quot[i]) : SW'(quot[i]);
         end
      end
   end

   // response assembly
   always_comb begin
      rsp_data_in = '0;
      rsp_data_in[acic_pkg::ENV_OUT_W-1:0] =
         acic_pkg::ENV_OUT_W'(env_in >> acic_pkg::ENV_OUT_SHIFT);
      rsp_data_in[acic_pkg::ENV_OUT_W +: SW]        = rate_in;
      rsp_data_in[acic_pkg::ENV_OUT_W + SW +: SW]   = cv_mean_in[0];
      rsp_data_in[acic_pkg::ENV_OUT_W + 2*SW +: SW] = cv_mean_in[1];
      rsp_data_in[acic_pkg::ENV_OUT_W + 3*SW +: SW] =
         pulse_act_in[0] ? acic_pkg::LEVEL_FULL : '0;
      rsp_data_in[acic_pkg::ENV_OUT_W + 4*SW +: SW] =
         pulse_act_in[1] ? acic_pkg::LEVEL_FULL : '0;
   end

   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_tready);

   // pipeline control
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            req_valid_ff <= req_tvalid;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // pipeline payload
   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         req_data_ff <= req_tdata;
      end
      if (advance) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // conditioner state, updated once per request
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 2; i++) begin
            hold_cnt_ff[i]  <= '0;
            pulse_act_ff[i] <= 1'b0;
            cv_sum_ff[i]    <= '0;
            cv_mean_ff[i]   <= '0;
         end
         env_ff         <= '0;
         prev_nonneg_ff <= 1'b0;
         cross_cnt_ff   <= '0;
         win_pos_ff     <= '0;
         rate_ff        <= '0;
         avg_pos_ff     <= '0;
      end else if (advance) begin
         for (int i = 0; i < 2; i++) begin
            hold_cnt_ff[i]  <= hold_cnt_in[i];
            pulse_act_ff[i] <= pulse_act_in[i];
            cv_sum_ff[i]    <= cv_sum_in[i];
            cv_mean_ff[i]   <= cv_mean_in[i];
         end
         env_ff         <= env_in;
         prev_nonneg_ff <= prev_nonneg_in;
         cross_cnt_ff   <= cross_cnt_in;
         win_pos_ff     <= win_pos_in;
         rate_ff        <= rate_in;
         avg_pos_ff     <= avg_pos_in;
      end
   end

   // an idle pulse never keeps a live hold count
   assign pulse_idle_ok = (pulse_act_ff[0] || hold_cnt_ff[0] == '0) &&
                          (pulse_act_ff[1] || hold_cnt_ff[1] == '0);
   // a closing window restarts position and count
   assign win_close = advance && zcr_done;
   assign win_clear = (win_pos_ff == '0) && (cross_cnt_ff == '0);

   // checks
   `ACIC_ASSERT_NEXT(a_advance_fills_rsp, clock, reset, advance, rsp_tvalid, "request lost")
   `ACIC_ASSERT_NOW(a_idle_pulse_cnt_zero, clock, reset, 1'b1, pulse_idle_ok, "idle count")
   `ACIC_ASSERT_NEXT(a_window_restart, clock, reset, win_close, win_clear, "window kept")
   `ACIC_ASSERT_NOW(a_avg_pos_range, clock, reset, 1'b1, avg_pos_ff < WINDOW_LEN, "avg position")
   `ACIC_ASSERT_NOW(a_env_bound, clock, reset, 1'b1, env_ff <= acic_pkg::ENV_MAX, "env high")

endmodule
